### src/plob_pkg.sv
// ============================================================================
// plob_pkg
// Shared types, widths and helpers for the price-level order book unit.
// ============================================================================
`timescale 1ns / 1ps

package plob_pkg;

  localparam int PRICE_W   = 10;
  localparam int ID_W      = 10;
  localparam int QTY_W     = 32;
  localparam int LQ_W      = 48;
  localparam int CNT_W     = 11;
  localparam int DEPTH_W   = 5;
  localparam int MAX_DEPTH = 16;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;                  // bit index inside a bitmap word
  localparam int WIDX_W    = PRICE_W - BIT_W;    // bitmap word index
  localparam int LVL_AW    = PRICE_W + 1;        // {side, price}
  localparam int BMP_AW    = WIDX_W + 1;         // {side, word}
  localparam int CLR_W     = LVL_AW;             // clearing sweep covers the level store

  localparam logic [LQ_W-1:0]  LQ_MAX  = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_CANCEL = 2'd1,
    FN_MODIFY = 2'd2,
    FN_LIST   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_UNKNOWN = 2'd1,
    STS_DUP     = 2'd2,
    STS_BADPRC  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ORD_RD,
    S_ORD_CHK,
    S_UPD_CAN,
    S_ADD_CHK,
    S_UPD_ADD,
    S_BB0,
    S_BB1,
    S_BB2,
    S_WAIT_RES,
    S_LFIND,
    S_LWORD,
    S_LOUT,
    S_WAIT_LVL
  } plob_state_t;

  typedef struct packed {
    logic    clr;
    logic    cap;
    logic    ord_rd;
    logic    rd_ord_lvl;
    logic    rd_in_lvl;
    logic    upd;
    logic    upd_add;
    logic    set_err;
    status_t err_code;
    logic    bb0;
    logic    bb1;
    logic    bb2;
    logic    list_init;
    logic    lfind;
    logic    lword;
    logic    out_res;
    logic    out_lvl;
    logic    out_empty;
  } plob_cmd_t;

  typedef struct packed {
    logic  clr_done;
    func_t func;
    logic  live;
    logic  price_zero;
    logic  wbits_nz;
    logic  smask_nz;
    logic  list_last;
    logic  out_fire;
  } plob_sts_t;

  function automatic logic [BIT_W-1:0] msb_idx(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [BIT_W-1:0] lsb_idx(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

### src/plob_ctrl.sv
// ============================================================================
// plob_ctrl
// Sequencer for the order book: clearing sweep, order updates, best-price
// search and level listing.
// ============================================================================
`timescale 1ns / 1ps

module plob_ctrl
  import plob_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  plob_sts_t sts,
  output plob_cmd_t cmd
);

  plob_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = S_ORD_RD;
      S_ORD_RD:   state_nxt = (sts.func == FN_LIST) ? S_BB0 : S_ORD_CHK;
      S_ORD_CHK: begin
        if (sts.func == FN_CANCEL) state_nxt = sts.live ? S_UPD_CAN : S_BB0;
        else if (sts.func == FN_MODIFY && sts.live) state_nxt = S_UPD_CAN;
        else state_nxt = S_ADD_CHK;
      end
      S_UPD_CAN:  state_nxt = (sts.func == FN_CANCEL) ? S_BB0 : S_ADD_CHK;
      S_ADD_CHK:  state_nxt = (sts.price_zero || sts.live) ? S_BB0 : S_UPD_ADD;
      S_UPD_ADD:  state_nxt = S_BB0;
      S_BB0:      state_nxt = S_BB1;
      S_BB1:      state_nxt = S_BB2;
      S_BB2:      state_nxt = (sts.func == FN_LIST) ? S_LFIND : S_WAIT_RES;
      S_WAIT_RES: if (sts.out_fire) state_nxt = S_IDLE;
      S_LFIND: begin
        if (sts.wbits_nz)      state_nxt = S_LOUT;
        else if (sts.smask_nz) state_nxt = S_LWORD;
        else                   state_nxt = S_WAIT_RES;
      end
      S_LWORD:    state_nxt = S_LFIND;
      S_LOUT:     state_nxt = S_WAIT_LVL;
      S_WAIT_LVL: if (sts.out_fire) state_nxt = sts.list_last ? S_IDLE : S_LFIND;
      default:    state_nxt = S_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    cmd.err_code = STS_OK;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
      end
      S_ORD_RD: cmd.ord_rd = 1'b1;
      S_ORD_CHK: begin
        if (sts.func == FN_CANCEL && !sts.live) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = STS_UNKNOWN;
        end else if (sts.live && (sts.func == FN_CANCEL || sts.func == FN_MODIFY)) begin
          cmd.rd_ord_lvl = 1'b1;
        end
      end
      S_UPD_CAN: cmd.upd = 1'b1;
      S_ADD_CHK: begin
        if (sts.price_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = STS_BADPRC;
        end else if (sts.live) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = STS_DUP;
        end else begin
          cmd.rd_in_lvl = 1'b1;
        end
      end
      S_UPD_ADD: begin
        cmd.upd     = 1'b1;
        cmd.upd_add = 1'b1;
      end
      S_BB0: cmd.bb0 = 1'b1;
      S_BB1: cmd.bb1 = 1'b1;
      S_BB2: begin
        cmd.bb2 = 1'b1;
        if (sts.func == FN_LIST) cmd.list_init = 1'b1;
        else                     cmd.out_res   = 1'b1;
      end
      S_WAIT_RES: ;
      S_LFIND: begin
        if (sts.wbits_nz || sts.smask_nz) cmd.lfind     = 1'b1;
        else                              cmd.out_empty = 1'b1;
      end
      S_LWORD:    cmd.lword   = 1'b1;
      S_LOUT:     cmd.out_lvl = 1'b1;
      S_WAIT_LVL: ;
      default: ;
    endcase
  end

endmodule

### src/plob_dp.sv
// ============================================================================
// plob_dp
// Order book datapath: order table, level totals, occupancy bitmaps and the
// result register.
// ============================================================================
`timescale 1ns / 1ps

module plob_dp
  import plob_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  plob_cmd_t           cmd,
  output plob_sts_t           sts,
  input  logic [1:0]          in_func,
  input  logic                in_side,
  input  logic [ID_W-1:0]     in_order_id,
  input  logic [PRICE_W-1:0]  in_price,
  input  logic [QTY_W-1:0]    in_quantity,
  input  logic [DEPTH_W-1:0]  in_depth,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PRICE_W-1:0]  out_level_price,
  output logic [LQ_W-1:0]     out_level_quantity,
  output logic [CNT_W-1:0]    out_level_orders,
  output logic [PRICE_W-1:0]  out_best_bid,
  output logic [PRICE_W-1:0]  out_best_ask,
  output logic signed [PRICE_W:0] out_spread,
  output logic [1:0]          out_status,
  output logic                out_last
);

  localparam int ORD_DW = 1 + PRICE_W + QTY_W;
  localparam int LVL_DW = LQ_W + CNT_W;

  // memories
  logic [ORD_DW-1:0] ord_mem  [0:(1<<ID_W)-1];
  logic              live_mem [0:(1<<ID_W)-1];
  logic [LVL_DW-1:0] lvl_mem  [0:(1<<LVL_AW)-1];
  logic [WORD_W-1:0] bmp_mem  [0:(1<<BMP_AW)-1];

  // captured input
  func_t              func_r;
  logic               side_r;
  logic [ID_W-1:0]    id_r;
  logic [PRICE_W-1:0] price_r;
  logic [QTY_W-1:0]   qty_r;
  logic [DEPTH_W-1:0] depth_r;

  // read data
  logic               ord_side_r;
  logic [PRICE_W-1:0] ord_price_r;
  logic [QTY_W-1:0]   ord_qty_r;
  logic               live_r;
  logic [LQ_W-1:0]    lq_rd_r;
  logic [CNT_W-1:0]   lc_rd_r;
  logic [WORD_W-1:0]  bmp_rd_r;

  logic               tgt_side_r;
  logic [PRICE_W-1:0] tgt_price_r;

  // pending single result
  logic [PRICE_W-1:0] res_lp_r;
  logic [LQ_W-1:0]    res_lq_r;
  logic [CNT_W-1:0]   res_lc_r;
  status_t            res_st_r;

  // best price search and list walk
  logic [1:0][WORD_W-1:0] sum_r;
  logic [WIDX_W-1:0]  bw_r;
  logic [PRICE_W-1:0] bb_r, ba_r;
  logic [WORD_W-1:0]  smask_r, wbits_r;
  logic [WIDX_W-1:0]  lw_r;
  logic [PRICE_W-1:0] lp_r;
  logic [DEPTH_W-1:0] lcnt_r;
  logic               llast_r;
  logic [CLR_W-1:0]   clr_cnt_r;

  // output register
  logic               out_valid_r;
  logic [PRICE_W-1:0] o_lp_r, o_bb_r, o_ba_r;
  logic [LQ_W-1:0]    o_lq_r;
  logic [CNT_W-1:0]   o_lc_r;
  logic [PRICE_W:0]   o_sp_r;
  status_t            o_st_r;
  logic               o_last_r;

  // level update arithmetic
  logic [LQ_W:0]      add_sum;
  logic [LQ_W-1:0]    new_q, can_q;
  logic [CNT_W-1:0]   new_c, can_c;
  logic [WORD_W-1:0]  new_word;
  logic [BIT_W-1:0]   list_bit;
  logic [WORD_W-1:0]  wbits_clr;
  logic [WIDX_W-1:0]  list_word;
  logic [DEPTH_W-1:0] lcnt_inc;
  logic [PRICE_W-1:0] ba_now, ba_sel;
  logic [PRICE_W:0]   sp_now;
  logic               out_fire;

  always_comb begin
    add_sum = {1'b0, lq_rd_r} + {{(LQ_W-QTY_W+1){1'b0}}, qty_r};
    can_q   = (lq_rd_r > {{(LQ_W-QTY_W){1'b0}}, ord_qty_r})
            ? lq_rd_r - {{(LQ_W-QTY_W){1'b0}}, ord_qty_r} : '0;
    can_c   = (lc_rd_r != '0) ? lc_rd_r - CNT_W'(1) : '0;
    if (cmd.upd_add) begin
      new_q = add_sum[LQ_W] ? LQ_MAX : add_sum[LQ_W-1:0];
      new_c = (lc_rd_r != CNT_MAX) ? lc_rd_r + CNT_W'(1) : lc_rd_r;
    end else if (can_q == '0 || can_c == '0) begin
      new_q = '0;
      new_c = '0;
    end else begin
      new_q = can_q;
      new_c = can_c;
    end
    new_word = bmp_rd_r;
    new_word[tgt_price_r[BIT_W-1:0]] = (new_q != '0);
  end

  always_comb begin
    list_bit  = side_r ? lsb_idx(wbits_r) : msb_idx(wbits_r);
    list_word = side_r ? lsb_idx(smask_r) : msb_idx(smask_r);
    wbits_clr = wbits_r;
    wbits_clr[list_bit] = 1'b0;
    lcnt_inc  = lcnt_r + DEPTH_W'(1);
    ba_now    = (sum_r[1] != '0) ? {bw_r, lsb_idx(bmp_rd_r)} : '0;
    ba_sel    = cmd.bb2 ? ba_now : ba_r;
    sp_now    = (bb_r == '0 || ba_sel == '0) ? '0 : {1'b0, ba_sel} - {1'b0, bb_r};
    out_fire  = out_valid_r && out_ready;
  end

  // order table and live flags
  always_ff @(posedge clk) begin
    if (cmd.upd && cmd.upd_add) ord_mem[id_r] <= {side_r, price_r, qty_r};
    if (cmd.ord_rd) {ord_side_r, ord_price_r, ord_qty_r} <= ord_mem[id_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr)      live_mem[clr_cnt_r[ID_W-1:0]] <= 1'b0;
    else if (cmd.upd) live_mem[id_r] <= cmd.upd_add;
  end

  // level totals
  always_ff @(posedge clk) begin
    if (cmd.clr)      lvl_mem[clr_cnt_r] <= '0;
    else if (cmd.upd) lvl_mem[{tgt_side_r, tgt_price_r}] <= {new_q, new_c};
    if (cmd.rd_ord_lvl)
      {lq_rd_r, lc_rd_r} <= lvl_mem[{ord_side_r, ord_price_r}];
    else if (cmd.rd_in_lvl)
      {lq_rd_r, lc_rd_r} <= lvl_mem[{side_r, price_r}];
    else if (cmd.lfind && wbits_r != '0)
      {lq_rd_r, lc_rd_r} <= lvl_mem[{side_r, lw_r, list_bit}];
  end

  // occupancy bitmaps
  always_ff @(posedge clk) begin
    if (cmd.clr)      bmp_mem[clr_cnt_r[BMP_AW-1:0]] <= '0;
    else if (cmd.upd) bmp_mem[{tgt_side_r, tgt_price_r[PRICE_W-1:BIT_W]}] <= new_word;
    if (cmd.rd_ord_lvl)
      bmp_rd_r <= bmp_mem[{ord_side_r, ord_price_r[PRICE_W-1:BIT_W]}];
    else if (cmd.rd_in_lvl)
      bmp_rd_r <= bmp_mem[{side_r, price_r[PRICE_W-1:BIT_W]}];
    else if (cmd.bb0)
      bmp_rd_r <= bmp_mem[{1'b0, msb_idx(sum_r[0])}];
    else if (cmd.bb1)
      bmp_rd_r <= bmp_mem[{1'b1, lsb_idx(sum_r[1])}];
    else if (cmd.lfind && wbits_r == '0)
      bmp_rd_r <= bmp_mem[{side_r, list_word}];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + CLR_W'(1);
      if (cmd.upd)
        sum_r[tgt_side_r][tgt_price_r[PRICE_W-1:BIT_W]] <= (new_word != '0);
      if (cmd.out_res || cmd.out_lvl || cmd.out_empty) out_valid_r <= 1'b1;
      else if (out_fire)                                out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      func_r  <= func_t'(in_func);
      side_r  <= in_side;
      id_r    <= in_order_id;
      price_r <= in_price;
      qty_r   <= in_quantity;
      if (in_depth == '0)                          depth_r <= DEPTH_W'(1);
      else if (in_depth > DEPTH_W'(MAX_DEPTH))     depth_r <= DEPTH_W'(MAX_DEPTH);
      else                                         depth_r <= in_depth;
    end
    if (cmd.ord_rd) live_r <= live_mem[id_r];
    if (cmd.rd_ord_lvl) begin
      tgt_side_r  <= ord_side_r;
      tgt_price_r <= ord_price_r;
    end else if (cmd.rd_in_lvl) begin
      tgt_side_r  <= side_r;
      tgt_price_r <= price_r;
    end
    if (cmd.upd) begin
      live_r   <= cmd.upd_add;
      res_lp_r <= tgt_price_r;
      res_lq_r <= new_q;
      res_lc_r <= new_c;
      res_st_r <= STS_OK;
    end else if (cmd.set_err) begin
      res_lp_r <= '0;
      res_lq_r <= '0;
      res_lc_r <= '0;
      res_st_r <= cmd.err_code;
    end
    if (cmd.bb0) bw_r <= msb_idx(sum_r[0]);
    if (cmd.bb1) begin
      bb_r <= (sum_r[0] != '0) ? {bw_r, msb_idx(bmp_rd_r)} : '0;
      bw_r <= lsb_idx(sum_r[1]);
    end
    if (cmd.bb2) ba_r <= ba_now;
    if (cmd.list_init) begin
      smask_r <= sum_r[side_r];
      wbits_r <= '0;
      lcnt_r  <= '0;
    end
    if (cmd.lfind) begin
      if (wbits_r != '0) begin
        wbits_r <= wbits_clr;
        lp_r    <= {lw_r, list_bit};
        lcnt_r  <= lcnt_inc;
        llast_r <= (wbits_clr == '0 && smask_r == '0) || (lcnt_inc == depth_r);
      end else begin
        smask_r[list_word] <= 1'b0;
        lw_r <= list_word;
      end
    end
    if (cmd.lword) wbits_r <= bmp_rd_r;
    if (cmd.out_res || cmd.out_lvl || cmd.out_empty) begin
      o_bb_r <= bb_r;
      o_ba_r <= ba_sel;
      o_sp_r <= sp_now;
    end
    if (cmd.out_res) begin
      o_lp_r   <= res_lp_r;
      o_lq_r   <= res_lq_r;
      o_lc_r   <= res_lc_r;
      o_st_r   <= res_st_r;
      o_last_r <= 1'b1;
    end else if (cmd.out_lvl) begin
      o_lp_r   <= lp_r;
      o_lq_r   <= lq_rd_r;
      o_lc_r   <= lc_rd_r;
      o_st_r   <= STS_OK;
      o_last_r <= llast_r;
    end else if (cmd.out_empty) begin
      o_lp_r   <= '0;
      o_lq_r   <= '0;
      o_lc_r   <= '0;
      o_st_r   <= STS_OK;
      o_last_r <= 1'b1;
    end
  end

  always_comb begin
    sts.clr_done   = (clr_cnt_r == '1);
    sts.func       = func_r;
    sts.live       = live_r;
    sts.price_zero = (price_r == '0);
    sts.wbits_nz   = (wbits_r != '0);
    sts.smask_nz   = (smask_r != '0);
    sts.list_last  = llast_r;
    sts.out_fire   = out_fire;
  end

  assign out_valid          = out_valid_r;
  assign out_level_price    = o_lp_r;
  assign out_level_quantity = o_lq_r;
  assign out_level_orders   = o_lc_r;
  assign out_best_bid       = o_bb_r;
  assign out_best_ask       = o_ba_r;
  assign out_spread         = o_sp_r;
  assign out_status         = o_st_r;
  assign out_last           = o_last_r;

endmodule

### src/price_level_order_book_unit.sv
// ============================================================================
// price_level_order_book_unit
// Limit order book keeping per-order slots and per-side price-level totals.
// ============================================================================
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   in_     | input     | in_valid/in_ready  | func, side, order_id, price,
//           |           |                    | quantity, depth
//   out_    | output    | out_valid/out_ready| level price/quantity/orders, best
//           |           |                    | bid/ask, spread, status, last
//
// - an add, a cancel or a modify of a live id runs the order read, the checks,
//   the level read-modify-write and a 3-step best search before its result; a
//   rejected request skips the final level write
// - a level listing runs the order read and the best search, then walks the
//   side's bitmap from the best price, reading each new word before its levels
// - one item is worked at a time; in_ready rises again once the last result
//   of the previous item has been taken
// - after reset a clearing sweep runs over the level store, live flags and
//   bitmaps; no item is taken during it
// - out_ready low simply holds the result register and pauses the sequencer
//
`timescale 1ns / 1ps

module price_level_order_book_unit
  import plob_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_func,
  input  logic                    in_side,
  input  logic [ID_W-1:0]         in_order_id,
  input  logic [PRICE_W-1:0]      in_price,
  input  logic [QTY_W-1:0]        in_quantity,
  input  logic [DEPTH_W-1:0]      in_depth,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PRICE_W-1:0]      out_level_price,
  output logic [LQ_W-1:0]         out_level_quantity,
  output logic [CNT_W-1:0]        out_level_orders,
  output logic [PRICE_W-1:0]      out_best_bid,
  output logic [PRICE_W-1:0]      out_best_ask,
  output logic signed [PRICE_W:0] out_spread,
  output logic [1:0]              out_status,
  output logic                    out_last
);

  // command and status between sequencer and datapath
  plob_cmd_t cmd;
  plob_sts_t sts;

  // sequencer: clearing sweep, update steps, best search, list walk
  plob_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: order table, level totals, occupancy bitmaps, result register
  plob_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_func),
    .in_side            (in_side),
    .in_order_id        (in_order_id),
    .in_price           (in_price),
    .in_quantity        (in_quantity),
    .in_depth           (in_depth),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_level_price    (out_level_price),
    .out_level_quantity (out_level_quantity),
    .out_level_orders   (out_level_orders),
    .out_best_bid       (out_best_bid),
    .out_best_ask       (out_best_ask),
    .out_spread         (out_spread),
    .out_status         (out_status),
    .out_last           (out_last)
  );

endmodule

### src/plob_chk.sv
// ============================================================================
// plob_chk
// Port-level checks for the price-level order book unit.
// ============================================================================
`timescale 1ns / 1ps

module plob_chk
  import plob_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [PRICE_W-1:0]      out_level_price,
  input logic [LQ_W-1:0]         out_level_quantity,
  input logic [CNT_W-1:0]        out_level_orders,
  input logic [PRICE_W-1:0]      out_best_bid,
  input logic [PRICE_W-1:0]      out_best_ask,
  input logic signed [PRICE_W:0] out_spread,
  input logic [1:0]              out_status,
  input logic                    out_last
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // an empty side forces a zero spread
  a_spread: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_best_bid == '0 || out_best_ask == '0) |-> out_spread == '0)
    else $error("spread nonzero with an empty side");

  // rejected requests report no level and end the item
  a_err_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STS_OK |-> out_level_price == '0 &&
      out_level_quantity == '0 && out_level_orders == '0 && out_last)
    else $error("error result carries a level");

  // no new transfer is taken while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken with a result pending");

  // an input transfer starts work, so ready drops right after it
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after an input transfer");

endmodule

bind price_level_order_book_unit plob_chk u_plob_chk (.*);

### verif/tb_top.sv
// ============================================================================
// tb_top
// Regression for the price-level order book: a queue-fed driver, a monitor
// checking every result transfer against a behavioral book, random idling.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
  import plob_pkg::*;

  localparam int NLVL = 1024;
  localparam int NORD = 1024;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic [1:0]         func;
    logic               side;
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [DEPTH_W-1:0] depth;
  } order_msg_t;

  typedef struct packed {
    logic [PRICE_W-1:0]  lprice;
    logic [LQ_W-1:0]     lqty;
    logic [CNT_W-1:0]    lcnt;
    logic [PRICE_W-1:0]  bid;
    logic [PRICE_W-1:0]  ask;
    logic [PRICE_W:0]    spread;
    logic [1:0]          status;
    logic                last;
  } book_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_func = '0;
  logic in_side = 1'b0;
  logic [ID_W-1:0] in_order_id = '0;
  logic [PRICE_W-1:0] in_price = '0;
  logic [QTY_W-1:0] in_quantity = '0;
  logic [DEPTH_W-1:0] in_depth = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PRICE_W-1:0] out_level_price;
  logic [LQ_W-1:0] out_level_quantity;
  logic [CNT_W-1:0] out_level_orders;
  logic [PRICE_W-1:0] out_best_bid;
  logic [PRICE_W-1:0] out_best_ask;
  logic signed [PRICE_W:0] out_spread;
  logic [1:0] out_status;
  logic out_last;

  price_level_order_book_unit dut (.*);

  // behavioral copy of the book
  logic               live_tbl [NORD];
  logic               side_tbl [NORD];
  logic [PRICE_W-1:0] price_tbl [NORD];
  logic [QTY_W-1:0]   qty_tbl [NORD];
  logic [LQ_W-1:0]    lvl_qty [2][NLVL];
  logic [CNT_W-1:0]   lvl_cnt [2][NLVL];

  order_msg_t   pending_msgs[$];
  book_report_t expected_reports[$];

  int cycle_cnt = 0;
  int mismatches = 0;
  int reports_seen = 0;
  int msgs_sent = 0;
  bit stim_done = 1'b0;
  bit calm = 1'b0;     // no idling in the final stretch
  int drv_idle = 0;
  int mon_idle = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void expect_report(book_report_t r);
    expected_reports.insert(expected_reports.size(), r);
  endfunction

  function automatic book_report_t make_report(logic [PRICE_W-1:0] lp, logic [LQ_W-1:0] lq,
                                               logic [CNT_W-1:0] lc, status_t st, logic lst);
    book_report_t r;
    int bb;
    int ba;
    bb = 0;
    ba = 0;
    for (int p = NLVL - 1; p > 0; p--) if (bb == 0 && lvl_qty[0][p] != 0) bb = p;
    for (int p = 1; p < NLVL; p++) if (ba == 0 && lvl_qty[1][p] != 0) ba = p;
    r.lprice = lp;
    r.lqty = lq;
    r.lcnt = lc;
    r.bid = PRICE_W'(bb);
    r.ask = PRICE_W'(ba);
    r.spread = (bb == 0 || ba == 0) ? '0 : (PRICE_W + 1)'(ba - bb);
    r.status = st;
    r.last = lst;
    return r;
  endfunction

  function automatic void pull_order(int id);
    int s;
    int p;
    logic [LQ_W-1:0] oq;
    s = int'(side_tbl[id]);
    p = int'(price_tbl[id]);
    oq = {{(LQ_W-QTY_W){1'b0}}, qty_tbl[id]};
    lvl_qty[s][p] = (lvl_qty[s][p] > oq) ? lvl_qty[s][p] - oq : '0;
    if (lvl_cnt[s][p] > 0) lvl_cnt[s][p]--;
    if (lvl_qty[s][p] == 0 || lvl_cnt[s][p] == 0) begin
      lvl_qty[s][p] = '0;
      lvl_cnt[s][p] = '0;
    end
    live_tbl[id] = 1'b0;
  endfunction

  // apply one accepted message to the book and queue what it should report
  function automatic void apply_msg(order_msg_t m);
    int n;
    int d;
    int p;
    logic [LQ_W:0] sum;
    n = 0;
    if (m.func == FN_LIST) begin
      d = (m.depth == 0) ? 1 : ((m.depth > MAX_DEPTH) ? MAX_DEPTH : int'(m.depth));
      for (int k = 1; k < NLVL && n < d; k++) begin
        p = m.side ? k : NLVL - k;
        if (lvl_qty[m.side][p] != 0) begin
          expect_report(make_report(PRICE_W'(p), lvl_qty[m.side][p], lvl_cnt[m.side][p],
                                    STS_OK, 1'b0));
          n++;
        end
      end
      if (n == 0) expect_report(make_report('0, '0, '0, STS_OK, 1'b1));
      else expected_reports[$].last = 1'b1;
      return;
    end
    if (m.func == FN_CANCEL) begin
      if (!live_tbl[m.id]) begin
        expect_report(make_report('0, '0, '0, STS_UNKNOWN, 1'b1));
        return;
      end
      n = int'(side_tbl[m.id]);
      p = int'(price_tbl[m.id]);
      pull_order(m.id);
      expect_report(make_report(PRICE_W'(p), lvl_qty[n][p], lvl_cnt[n][p], STS_OK, 1'b1));
      return;
    end
    if (m.func == FN_MODIFY && live_tbl[m.id]) pull_order(m.id);
    if (m.price == 0) begin
      expect_report(make_report('0, '0, '0, STS_BADPRC, 1'b1));
      return;
    end
    if (live_tbl[m.id]) begin
      expect_report(make_report('0, '0, '0, STS_DUP, 1'b1));
      return;
    end
    sum = {1'b0, lvl_qty[m.side][m.price]} + {{(LQ_W-QTY_W+1){1'b0}}, m.qty};
    lvl_qty[m.side][m.price] = sum[LQ_W] ? LQ_MAX : sum[LQ_W-1:0];
    if (lvl_cnt[m.side][m.price] != CNT_MAX) lvl_cnt[m.side][m.price]++;
    live_tbl[m.id] = 1'b1;
    side_tbl[m.id] = m.side;
    price_tbl[m.id] = m.price;
    qty_tbl[m.id] = m.qty;
    expect_report(make_report(m.price, lvl_qty[m.side][m.price],
                              lvl_cnt[m.side][m.price], STS_OK, 1'b1));
  endfunction

  function automatic void queue_msg(func_t f, int s, int id, int p, logic [31:0] q, int d);
    order_msg_t m;
    m.func = f;
    m.side = 1'(s);
    m.id = ID_W'(id);
    m.price = PRICE_W'(p);
    m.qty = q;
    m.depth = DEPTH_W'(d);
    pending_msgs.insert(pending_msgs.size(), m);
  endfunction

  // stimulus: directed corner cases, then mostly live-book traffic in a small id pool
  initial begin
    int f;
    int pool;
    for (int i = 0; i < NORD; i++) live_tbl[i] = 1'b0;
    for (int s = 0; s < 2; s++)
      for (int p = 0; p < NLVL; p++) begin
        lvl_qty[s][p] = '0;
        lvl_cnt[s][p] = '0;
      end
    queue_msg(FN_LIST, 0, 0, 0, 0, 0);                // empty book list, depth zero
    queue_msg(FN_CANCEL, 0, 5, 0, 0, 1);              // cancel of an unknown id
    queue_msg(FN_ADD, 0, 0, 0, 32'd7, 1);             // price zero is invalid
    queue_msg(FN_ADD, 0, 1, 1023, '1, 1);             // top bid, full quantity
    queue_msg(FN_ADD, 0, 2, 1023, '1, 1);
    for (int i = 3; i < 3 + 16; i++)                  // push the level toward saturation
      queue_msg(FN_ADD, 0, i, 1023, '1, 1);
    queue_msg(FN_ADD, 1, 1023, 1, 32'd1, 1);          // lowest ask
    queue_msg(FN_ADD, 1, 1023, 2, 32'd1, 1);          // duplicate id
    queue_msg(FN_MODIFY, 1, 1023, 700, 32'd9, 1);     // modify moves the order
    queue_msg(FN_MODIFY, 0, 900, 0, 32'd9, 1);        // modify of dead id to bad price
    queue_msg(FN_CANCEL, 0, 1, 0, 0, 1);
    queue_msg(FN_LIST, 0, 0, 0, 0, 31);               // depth above the maximum
    queue_msg(FN_LIST, 1, 0, 0, 0, 16);
    for (int i = 1; i < 19; i++) queue_msg(FN_CANCEL, 0, i, 0, 0, 1);
    queue_msg(FN_CANCEL, 1, 1023, 0, 0, 1);
    for (int i = 0; i < 263; i++) begin
      f = $urandom_range(0, 99);
      pool = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NORD - 1) : $urandom_range(0, 31);
      if (f < 40)
        queue_msg(FN_ADD, $urandom_range(0, 1), pool,
                  ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, NLVL - 1),
                  ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 1000),
                  $urandom_range(0, 31));
      else if (f < 65)
        queue_msg(FN_CANCEL, $urandom_range(0, 1), pool, $urandom_range(0, NLVL - 1),
                  $urandom(), $urandom_range(0, 31));
      else if (f < 85)
        queue_msg(FN_MODIFY, $urandom_range(0, 1), pool,
                  ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, NLVL - 1),
                  $urandom(), $urandom_range(0, 31));
      else
        queue_msg(FN_LIST, $urandom_range(0, 1), $urandom_range(0, NORD - 1),
                  $urandom_range(0, NLVL - 1), $urandom(), $urandom_range(0, 31));
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: one message per transfer, random idle bursts between them
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        apply_msg({in_func, in_side, in_order_id, in_price, in_quantity, in_depth});
        msgs_sent <= msgs_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (drv_idle > 0) begin
          drv_idle <= drv_idle - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          drv_idle <= $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else if (pending_msgs.size() > 0) begin
          order_msg_t m;
          m = pending_msgs.pop_front();
          {in_func, in_side, in_order_id, in_price, in_quantity, in_depth} <= m;
          in_valid <= 1'b1;
          calm <= (pending_msgs.size() < 40);
        end else begin
          in_valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // monitor: random backpressure, each result transfer compared with the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        book_report_t got;
        book_report_t want;
        got = {out_level_price, out_level_quantity, out_level_orders, out_best_bid,
               out_best_ask, out_spread, out_status, out_last};
        reports_seen <= reports_seen + 1;
        if (expected_reports.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result transfer: %p", got);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("mismatch\n  exp %p\n  got %p", want, got);
          end
        end
      end
      if (mon_idle > 0) begin
        mon_idle <= mon_idle - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        mon_idle <= $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (stim_done && expected_reports.size() == 0);
    repeat (30) @(posedge clk);
    $display("sent %0d order messages, checked %0d book reports", msgs_sent, reports_seen);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("price_level_order_book_unit regression: pass");
    end else begin
      $display("price_level_order_book_unit regression: fail");
    end
    $finish;
  end

  // run limit: covers the clearing sweep and worst-case listing with stalls
  always @(posedge clk) begin
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout with %0d results outstanding", expected_reports.size());
      $display("price_level_order_book_unit regression: fail");
      $finish;
    end
  end

endmodule

### sim.f
src/plob_pkg.sv
src/plob_ctrl.sv
src/plob_dp.sv
src/price_level_order_book_unit.sv
src/plob_chk.sv
verif/tb_top.sv
